// ===== sv/asf_pkg.sv =====
package asf_pkg;

    localparam int DEPTH_LOG2  = 12;
    localparam int SAMPLE_BITS = 32;
    localparam int DEPTH       = 1 << DEPTH_LOG2;
    localparam int PTR_BITS    = DEPTH_LOG2 + 1;

    localparam int WORD_BITS   = 32;
    localparam int MOVED_BITS  = 2;
    localparam int FILL_BITS   = 13;
    localparam int CNT_BITS    = 32;
    localparam int OP_BITS     = 3;

    localparam logic [OP_BITS-1:0] OP_PUSH_ONE  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUSH_PAIR = 3'd1;
    localparam logic [OP_BITS-1:0] OP_POP_ONE   = 3'd2;
    localparam logic [OP_BITS-1:0] OP_POP_PAIR  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_CLEAR     = 3'd4;
    localparam logic [OP_BITS-1:0] OP_RESET_CNT = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_SECOND,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic first_step;
        logic second_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_second;
    } dp_status_t;

    function automatic logic [CNT_BITS-1:0] sat_add(
        input logic [CNT_BITS-1:0]   a,
        input logic [MOVED_BITS-1:0] inc
    );
        logic [CNT_BITS:0] sum;
        sum = {1'b0, a} + (CNT_BITS+1)'(inc);
        return sum[CNT_BITS] ? {CNT_BITS{1'b1}} : sum[CNT_BITS-1:0];
    endfunction

endpackage

// ===== sv/audio_sample_fifo_with_stats_unit.sv =====
// Channel  | Port group          | Contents (low bit first)
// ---------+---------------------+------------------------------------------------------
// input    | s_tvalid/tready     | tuser: operation[2:0]
//          |                     | tdata: first_sample[31:0], second_sample[63:32]
// output   | m_tvalid/tready     | tdata: left_out, right_out, moved_count, fill_level,
//          |                     |        drop_total, underrun_total, zero pad
//
// An item passes through accept, a first store step, a second store step (only for pair ops
// that move two samples) and result load; single push/pop, clear, counter reset and refused
// pair ops skip the second step. The sample store takes one access per step.
// Result sits in an output register; the next item is accepted while it waits.
// A stalled output holds the block at result load until the transfer completes.
// Reset clears pointers and counters at once; the sample store has no clearing pass.
module audio_sample_fifo_with_stats_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // first_sample[31:0], second_sample[63:32]
    input  logic [2:0]   s_tuser,   // operation[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // left_out[31:0], right_out[63:32], moved_count[65:64],
                                    // fill_level[78:66], drop_total[110:79],
                                    // underrun_total[142:111], zero[143]
);

    asf_pkg::ctrl_cmd_t  cmd;
    asf_pkg::dp_status_t status;

    logic [asf_pkg::WORD_BITS-1:0]  left_out;
    logic [asf_pkg::WORD_BITS-1:0]  right_out;
    logic [asf_pkg::MOVED_BITS-1:0] moved_count;
    logic [asf_pkg::FILL_BITS-1:0]  fill_level;
    logic [asf_pkg::CNT_BITS-1:0]   drop_total;
    logic [asf_pkg::CNT_BITS-1:0]   underrun_total;

    asf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    asf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (s_tuser),
        .first_sample   (s_tdata[31:0]),
        .second_sample  (s_tdata[63:32]),
        .left_out       (left_out),
        .right_out      (right_out),
        .moved_count    (moved_count),
        .fill_level     (fill_level),
        .drop_total     (drop_total),
        .underrun_total (underrun_total)
    );

    assign m_tdata = {1'b0, underrun_total, drop_total, fill_level, moved_count,
                      right_out, left_out};

endmodule

// ===== sv/asf_ctrl.sv =====
module asf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  asf_pkg::dp_status_t    status,
    output asf_pkg::ctrl_cmd_t     cmd
);

    asf_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            asf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = asf_pkg::ST_FIRST;
                end
            end
            asf_pkg::ST_FIRST:
            begin
                state_next = status.need_second ? asf_pkg::ST_SECOND : asf_pkg::ST_LOAD;
            end
            asf_pkg::ST_SECOND:
            begin
                state_next = asf_pkg::ST_LOAD;
            end
            asf_pkg::ST_LOAD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = asf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            asf_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            asf_pkg::ST_FIRST:
            begin
                cmd.first_step = 1'b1;
            end
            asf_pkg::ST_SECOND:
            begin
                cmd.second_step = 1'b1;
            end
            asf_pkg::ST_LOAD:
            begin
                cmd.load_out = !out_valid_reg || m_tready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= asf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == asf_pkg::ST_FIRST))
        else $error("accepted transfer did not start processing");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> !$past(cmd.load_out))
        else $error("result overwritten while waiting");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn before transfer");
`endif

endmodule

// ===== sv/asf_datapath.sv =====
module asf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  asf_pkg::ctrl_cmd_t                  cmd,
    output asf_pkg::dp_status_t                 status,
    input  logic [asf_pkg::OP_BITS-1:0]         operation,
    input  logic [asf_pkg::WORD_BITS-1:0]       first_sample,
    input  logic [asf_pkg::WORD_BITS-1:0]       second_sample,
    output logic [asf_pkg::WORD_BITS-1:0]       left_out,
    output logic [asf_pkg::WORD_BITS-1:0]       right_out,
    output logic [asf_pkg::MOVED_BITS-1:0]      moved_count,
    output logic [asf_pkg::FILL_BITS-1:0]       fill_level,
    output logic [asf_pkg::CNT_BITS-1:0]        drop_total,
    output logic [asf_pkg::CNT_BITS-1:0]        underrun_total
);

    logic [asf_pkg::SAMPLE_BITS-1:0] mem [0:asf_pkg::DEPTH-1];

    logic [asf_pkg::OP_BITS-1:0]     op_reg;
    logic [asf_pkg::SAMPLE_BITS-1:0] first_reg;
    logic [asf_pkg::SAMPLE_BITS-1:0] second_reg;
    logic [asf_pkg::SAMPLE_BITS-1:0] left_reg;
    logic [asf_pkg::SAMPLE_BITS-1:0] rd_data_reg;
    logic                            ok_reg, ok_next;
    logic [asf_pkg::PTR_BITS-1:0]    wptr_reg, wptr_next;
    logic [asf_pkg::PTR_BITS-1:0]    rptr_reg, rptr_next;
    logic [asf_pkg::CNT_BITS-1:0]    drop_reg, drop_next;
    logic [asf_pkg::CNT_BITS-1:0]    underrun_reg, underrun_next;

    logic [asf_pkg::WORD_BITS-1:0]   left_out_reg, left_out_next;
    logic [asf_pkg::WORD_BITS-1:0]   right_out_reg, right_out_next;
    logic [asf_pkg::MOVED_BITS-1:0]  moved_reg, moved_next;
    logic [asf_pkg::FILL_BITS-1:0]   fill_out_reg;
    logic [asf_pkg::CNT_BITS-1:0]    drop_out_reg;
    logic [asf_pkg::CNT_BITS-1:0]    underrun_out_reg;

    logic [asf_pkg::PTR_BITS-1:0]    fill;
    logic                            ok_now;
    logic                            is_push;
    logic                            is_pop;
    logic                            is_pair;
    logic                            wr_en;
    logic                            rd_en;
    logic [asf_pkg::SAMPLE_BITS-1:0] wr_data;

    assign fill    = wptr_reg - rptr_reg;
    assign is_push = (op_reg == asf_pkg::OP_PUSH_ONE) || (op_reg == asf_pkg::OP_PUSH_PAIR);
    assign is_pop  = (op_reg == asf_pkg::OP_POP_ONE) || (op_reg == asf_pkg::OP_POP_PAIR);
    assign is_pair = (op_reg == asf_pkg::OP_PUSH_PAIR) || (op_reg == asf_pkg::OP_POP_PAIR);

    always_comb
    begin
        case (op_reg)
            asf_pkg::OP_PUSH_ONE:  ok_now = !fill[asf_pkg::DEPTH_LOG2];
            asf_pkg::OP_PUSH_PAIR: ok_now = fill < asf_pkg::PTR_BITS'(asf_pkg::DEPTH - 1);
            asf_pkg::OP_POP_ONE:   ok_now = fill != '0;
            asf_pkg::OP_POP_PAIR:  ok_now = fill > asf_pkg::PTR_BITS'(1);
            default:               ok_now = 1'b0;
        endcase
    end

    assign status.need_second = ok_now && is_pair;

    assign wr_en   = (cmd.first_step && ok_now && is_push)
                   || (cmd.second_step && op_reg == asf_pkg::OP_PUSH_PAIR);
    assign rd_en   = (cmd.first_step && ok_now && is_pop)
                   || (cmd.second_step && op_reg == asf_pkg::OP_POP_PAIR);
    assign wr_data = cmd.first_step ? first_reg : second_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg[asf_pkg::DEPTH_LOG2-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rptr_reg[asf_pkg::DEPTH_LOG2-1:0]];
        end
    end

    always_comb
    begin
        wptr_next     = wr_en ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next     = rd_en ? rptr_reg + 1'b1 : rptr_reg;
        drop_next     = drop_reg;
        underrun_next = underrun_reg;
        ok_next       = cmd.first_step ? ok_now : ok_reg;
        if (cmd.first_step)
        begin
            case (op_reg)
                asf_pkg::OP_PUSH_ONE:
                begin
                    if (!ok_now)
                    begin
                        drop_next = asf_pkg::sat_add(drop_reg, 2'd1);
                    end
                end
                asf_pkg::OP_PUSH_PAIR:
                begin
                    if (!ok_now)
                    begin
                        drop_next = asf_pkg::sat_add(drop_reg, 2'd2);
                    end
                end
                asf_pkg::OP_POP_ONE:
                begin
                    if (!ok_now)
                    begin
                        underrun_next = asf_pkg::sat_add(underrun_reg, 2'd1);
                    end
                end
                asf_pkg::OP_POP_PAIR:
                begin
                    if (!ok_now)
                    begin
                        underrun_next = asf_pkg::sat_add(underrun_reg, 2'd2);
                    end
                end
                asf_pkg::OP_CLEAR:
                begin
                    wptr_next = '0;
                    rptr_next = '0;
                end
                asf_pkg::OP_RESET_CNT:
                begin
                    drop_next     = '0;
                    underrun_next = '0;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        left_out_next  = '0;
        right_out_next = '0;
        moved_next     = '0;
        case (op_reg)
            asf_pkg::OP_PUSH_ONE:
            begin
                moved_next = ok_reg ? 2'd1 : 2'd0;
            end
            asf_pkg::OP_PUSH_PAIR:
            begin
                moved_next = ok_reg ? 2'd2 : 2'd0;
            end
            asf_pkg::OP_POP_ONE:
            begin
                moved_next    = ok_reg ? 2'd1 : 2'd0;
                left_out_next = ok_reg ? asf_pkg::WORD_BITS'(rd_data_reg) : '0;
            end
            asf_pkg::OP_POP_PAIR:
            begin
                moved_next     = ok_reg ? 2'd2 : 2'd0;
                left_out_next  = ok_reg ? asf_pkg::WORD_BITS'(left_reg) : '0;
                right_out_next = ok_reg ? asf_pkg::WORD_BITS'(rd_data_reg) : '0;
            end
            default:
            begin
                moved_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            drop_reg     <= '0;
            underrun_reg <= '0;
            ok_reg       <= 1'b0;
        end
        else
        begin
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            drop_reg     <= drop_next;
            underrun_reg <= underrun_next;
            ok_reg       <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= operation;
            first_reg  <= asf_pkg::SAMPLE_BITS'(first_sample);
            second_reg <= asf_pkg::SAMPLE_BITS'(second_sample);
        end
        if (cmd.second_step)
        begin
            left_reg <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            left_out_reg     <= left_out_next;
            right_out_reg    <= right_out_next;
            moved_reg        <= moved_next;
            fill_out_reg     <= asf_pkg::FILL_BITS'(fill);
            drop_out_reg     <= drop_reg;
            underrun_out_reg <= underrun_reg;
        end
    end

    assign left_out       = left_out_reg;
    assign right_out      = right_out_reg;
    assign moved_count    = moved_reg;
    assign fill_level     = fill_out_reg;
    assign drop_total     = drop_out_reg;
    assign underrun_total = underrun_out_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill[asf_pkg::DEPTH_LOG2] |-> (fill[asf_pkg::DEPTH_LOG2-1:0] == '0))
        else $error("fill level above depth");

    a_clear_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.first_step && op_reg == asf_pkg::OP_CLEAR) |=> (wptr_reg == '0 && rptr_reg == '0))
        else $error("clear did not reset pointers");

    a_drop_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.first_step && op_reg == asf_pkg::OP_RESET_CNT) |=> (drop_reg >= $past(drop_reg)))
        else $error("drop counter decreased");
`endif

endmodule

// ===== sim/audio_sample_fifo_with_stats_unit_test.sv =====
module audio_sample_fifo_with_stats_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [asf_pkg::OP_BITS-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [asf_pkg::OP_BITS-1:0] OP_UNDEF_HI = 3'd7;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SEGMENTS       = 30;
    localparam int SEGMENT_ITEMS  = 50;
    localparam int QUIET_SEGMENTS = 4;

    // matches m_tdata, lowest field last
    typedef struct packed {
        logic                           pad;
        logic [asf_pkg::CNT_BITS-1:0]   underrun_total;
        logic [asf_pkg::CNT_BITS-1:0]   drop_total;
        logic [asf_pkg::FILL_BITS-1:0]  fill_level;
        logic [asf_pkg::MOVED_BITS-1:0] moved_count;
        logic [asf_pkg::WORD_BITS-1:0]  right_out;
        logic [asf_pkg::WORD_BITS-1:0]  left_out;
    } fifo_result_t;

    class fifo_model;
        logic [asf_pkg::WORD_BITS-1:0] store [asf_pkg::DEPTH];
        logic [asf_pkg::PTR_BITS-1:0]  wr_ptr;
        logic [asf_pkg::PTR_BITS-1:0]  rd_ptr;
        logic [asf_pkg::CNT_BITS-1:0]  drops;
        logic [asf_pkg::CNT_BITS-1:0]  underruns;
        fifo_result_t                  expected_results[$];
        int                            failures;

        function new();
            wr_ptr    = '0;
            rd_ptr    = '0;
            drops     = '0;
            underruns = '0;
            failures  = 0;
        endfunction

        function automatic int level();
            logic [asf_pkg::PTR_BITS-1:0] diff;
            diff = wr_ptr - rd_ptr;
            return int'(diff);
        endfunction

        function automatic logic [asf_pkg::CNT_BITS-1:0] bump(
            logic [asf_pkg::CNT_BITS-1:0] cnt, int inc);
            if (cnt > {asf_pkg::CNT_BITS{1'b1}} - asf_pkg::CNT_BITS'(inc))
                return {asf_pkg::CNT_BITS{1'b1}};
            return cnt + asf_pkg::CNT_BITS'(inc);
        endfunction

        function automatic void put_word(logic [asf_pkg::WORD_BITS-1:0] word);
            store[wr_ptr[asf_pkg::DEPTH_LOG2-1:0]] = word;
            wr_ptr = wr_ptr + 1'b1;
        endfunction

        function automatic logic [asf_pkg::WORD_BITS-1:0] take_word();
            logic [asf_pkg::WORD_BITS-1:0] word;
            word   = store[rd_ptr[asf_pkg::DEPTH_LOG2-1:0]];
            rd_ptr = rd_ptr + 1'b1;
            return word;
        endfunction

        function automatic void accept_item(logic [asf_pkg::OP_BITS-1:0] op,
                                            logic [asf_pkg::WORD_BITS-1:0] first,
                                            logic [asf_pkg::WORD_BITS-1:0] second);
            fifo_result_t r;
            int           fill;
            r    = '0;
            fill = level();
            case (op)
                asf_pkg::OP_PUSH_ONE:
                    if (asf_pkg::DEPTH - fill >= 1)
                    begin
                        put_word(first);
                        r.moved_count = 2'd1;
                    end
                    else
                        drops = bump(drops, 1);
                asf_pkg::OP_PUSH_PAIR:
                    if (asf_pkg::DEPTH - fill >= 2)
                    begin
                        put_word(first);
                        put_word(second);
                        r.moved_count = 2'd2;
                    end
                    else
                        drops = bump(drops, 2);
                asf_pkg::OP_POP_ONE:
                    if (fill >= 1)
                    begin
                        r.left_out    = take_word();
                        r.moved_count = 2'd1;
                    end
                    else
                        underruns = bump(underruns, 1);
                asf_pkg::OP_POP_PAIR:
                    if (fill >= 2)
                    begin
                        r.left_out    = take_word();
                        r.right_out   = take_word();
                        r.moved_count = 2'd2;
                    end
                    else
                        underruns = bump(underruns, 2);
                asf_pkg::OP_CLEAR:
                begin
                    wr_ptr = '0;
                    rd_ptr = '0;
                end
                asf_pkg::OP_RESET_CNT:
                begin
                    drops     = '0;
                    underruns = '0;
                end
                default: ;
            endcase
            r.fill_level     = asf_pkg::FILL_BITS'(level());
            r.drop_total     = drops;
            r.underrun_total = underruns;
            expected_results.push_back(r);
        endfunction

        function automatic void compare_field(string name, logic [31:0] exp_val,
                                              logic [31:0] act_val);
            if (exp_val !== act_val)
            begin
                $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
                failures++;
            end
        endfunction

        function automatic void check_result(logic [143:0] data);
            fifo_result_t got;
            fifo_result_t want;
            got = data;
            if (expected_results.size() == 0)
            begin
                $error("result %0h arrived with nothing expected", data);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("left_out", want.left_out, got.left_out);
            compare_field("right_out", want.right_out, got.right_out);
            compare_field("moved_count", 32'(want.moved_count), 32'(got.moved_count));
            compare_field("fill_level", 32'(want.fill_level), 32'(got.fill_level));
            compare_field("drop_total", want.drop_total, got.drop_total);
            compare_field("underrun_total", want.underrun_total, got.underrun_total);
            compare_field("pad", 32'(want.pad), 32'(got.pad));
        endfunction
    endclass

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata  = '0;   // first_sample[31:0], second_sample[63:32]
    logic [2:0]   s_tuser  = '0;   // operation[2:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;         // left_out, right_out, moved_count, fill_level,
                                   // drop_total, underrun_total, zero pad

    logic         idle_enable = 1'b1;
    int           rx_hold     = 0;
    int           quiet_cycles = 0;
    fifo_model    model = new();

    audio_sample_fifo_with_stats_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check transfers, random stall bursts
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            model.check_result(m_tdata);
        if (!rst_n)
            m_tready <= 1'b0;
        else if (!idle_enable)
        begin
            rx_hold  <= 0;
            m_tready <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            rx_hold  <= $urandom_range(1, 9);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input logic [asf_pkg::OP_BITS-1:0] op, input logic [31:0] first,
                             input logic [31:0] second);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {second, first};
        do
            @(posedge clk);
        while (!s_tready);
        model.accept_item(op, first, second);
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic send_random(input int push_bias);
        logic [asf_pkg::OP_BITS-1:0] op;
        int                          r;
        r = $urandom_range(0, 99);
        if (r < 2)
            op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;
        else if (r < 4)
            op = asf_pkg::OP_CLEAR;
        else if (r < 7)
            op = asf_pkg::OP_RESET_CNT;
        else if (r < 7 + push_bias)
            op = $urandom_range(0, 1) ? asf_pkg::OP_PUSH_PAIR : asf_pkg::OP_PUSH_ONE;
        else
            op = $urandom_range(0, 1) ? asf_pkg::OP_POP_PAIR : asf_pkg::OP_POP_ONE;
        send_item(op, rand_sample(), rand_sample());
    endtask

    initial
    begin
        int seg;
        int k;
        int bias;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pops, pair edge cases, undefined ops, clear and counter reset
        send_item(asf_pkg::OP_POP_ONE, 32'h0, 32'h0);
        send_item(asf_pkg::OP_POP_PAIR, 32'h0, 32'h0);
        send_item(asf_pkg::OP_PUSH_ONE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(asf_pkg::OP_PUSH_ONE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(asf_pkg::OP_PUSH_PAIR, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(asf_pkg::OP_POP_PAIR, 32'h0, 32'h0);
        send_item(asf_pkg::OP_POP_PAIR, 32'h0, 32'h0);
        send_item(asf_pkg::OP_POP_ONE, 32'h0, 32'h0);
        send_item(asf_pkg::OP_POP_PAIR, 32'h0, 32'h0);
        send_item(asf_pkg::OP_PUSH_PAIR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(asf_pkg::OP_PUSH_ONE, 32'h8000_0001, 32'h0);
        send_item(asf_pkg::OP_POP_ONE, 32'h0, 32'h0);
        send_item(OP_UNDEF_LO, 32'h1234_5678, 32'h9ABC_DEF0);
        send_item(OP_UNDEF_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(asf_pkg::OP_CLEAR, 32'h0, 32'h0);
        send_item(asf_pkg::OP_POP_ONE, 32'h0, 32'h0);
        send_item(asf_pkg::OP_RESET_CNT, 32'h0, 32'h0);
        send_item(asf_pkg::OP_PUSH_PAIR, 32'h0000_0000, 32'h0000_0000);
        send_item(asf_pkg::OP_POP_ONE, 32'h0, 32'h0);
        send_item(asf_pkg::OP_POP_ONE, 32'h0, 32'h0);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == SEGMENTS - QUIET_SEGMENTS)
                idle_enable = 1'b0;
            bias = $urandom_range(20, 72);
            for (k = 0; k < SEGMENT_ITEMS; k++)
                send_random(bias);
        end

        s_tvalid <= 1'b0;
        while (model.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (model.expected_results.size() != 0)
        begin
            $error("%0d results never arrived", model.expected_results.size());
            model.failures++;
        end
        if (model.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
